@@ rtl/fifo_queue_with_keyed_removal_macros.svh @@
// Assertion macros used by the checker file of the keyed queue.
`ifndef FIFO_QUEUE_WITH_KEYED_REMOVAL_MACROS_SVH
`define FIFO_QUEUE_WITH_KEYED_REMOVAL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FQKR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed queue check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FQKR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed queue check failed");

`endif

@@ rtl/fqkr_pkg.sv @@
// Types and constants of the keyed first-in first-out queue.
package fqkr_pkg;

	localparam int DEPTH        = 16;
	localparam int KEY_BITS     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int CNT_BITS     = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_DEQ = 2'd1,
		FUNC_REM = 2'd2
	} func_t;

	typedef struct packed {
		func_t                   func;
		logic [KEY_BITS-1:0]     item_key;
		logic [PAYLOAD_BITS-1:0] item_payload;
	} cmd_t;

	typedef struct packed {
		logic                    ok;
		logic [KEY_BITS-1:0]     out_key;
		logic [PAYLOAD_BITS-1:0] out_payload;
		logic [CNT_BITS-1:0]     occupancy;
		logic                    is_empty;
	} res_t;

	// Operation broadcast to every cell in the accept cycle.
	typedef struct packed {
		logic                    enq;
		logic                    deq;
		logic                    rem;
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
	} cell_ctrl_t;

	// Contents one cell shows to its neighbor toward the front.
	typedef struct packed {
		logic                    valid;
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
	} cell_link_t;

endpackage

@@ rtl/fqkr_cell.sv @@
// One slot of the queue: holds an entry, loads on enqueue, shifts toward the front.
module fqkr_cell
	import fqkr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       prev_valid,
	input  logic       hit_in,
	input  cell_link_t next,
	output cell_link_t here,
	output logic       hit_out
);

	logic                    valid_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    load;
	logic                    shift;

	// The hit flag ripples from front to back: once a match is seen, every
	// cell from there on takes its neighbor's entry, closing the gap.
	assign hit_out = hit_in | (valid_q && (key_q == ctrl.key));
	// Only the first free slot sees a valid neighbor in front of it.
	assign load    = ctrl.enq && !valid_q && prev_valid;
	assign shift   = ctrl.deq || (ctrl.rem && hit_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (shift) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q     <= ctrl.key;
			payload_q <= ctrl.payload;
		end else if (shift) begin
			key_q     <= next.key;
			payload_q <= next.payload;
		end
	end

	assign here = '{valid: valid_q, key: key_q, payload: payload_q};

endmodule

@@ rtl/fifo_queue_with_keyed_removal.sv @@
// Top level of the keyed first-in first-out queue: row of slot cells and result register.
// A transaction is taken on every clock edge with start high; busy is never raised, so a new
// request may follow in the very next cycle. Each request gives exactly one result, shown on
// res with done high for one cycle, in the cycle after acceptance, and the receiver cannot hold
// it off. The queue is a row of DEPTH cells, slot 0 at the front; every cell compares its key
// in parallel and a one-bit hit chain runs from front to back, so the whole update of one
// request completes in the accept cycle and that chain sets the clock period. Stored entries
// need no clearing after reset: only slots marked valid are ever read.
module fifo_queue_with_keyed_removal
	import fqkr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t res
);

	cell_ctrl_t           ctrl;
	cell_link_t           link [DEPTH];
	logic [DEPTH-1:0]     hit;
	logic                 accept;
	logic                 full;
	logic                 ok;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  count_next;
	logic                 done_q;
	res_t                 res_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = link[DEPTH-1].valid;

	always_comb begin
		ctrl         = '0;
		ctrl.key     = cmd.item_key;
		ctrl.payload = cmd.item_payload;
		ok           = 1'b0;
		case (cmd.func)
			FUNC_ENQ: begin
				ctrl.enq = accept;
				ok       = !full;
			end
			FUNC_DEQ: begin
				ctrl.deq = accept && link[0].valid;
				ok       = link[0].valid;
			end
			FUNC_REM: begin
				ctrl.rem = accept;
				ok       = hit[DEPTH-1];
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (ok && (cmd.func == FUNC_ENQ)) begin
			count_next = count_q + CNT_BITS'(1);
		end else if (ok) begin
			count_next = count_q - CNT_BITS'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic       prev_valid;
		logic       hit_in;
		cell_link_t next;

		if (i == 0) begin : g_front
			assign prev_valid = 1'b1;
			assign hit_in     = 1'b0;
		end else begin : g_inner
			assign prev_valid = link[i-1].valid;
			assign hit_in     = hit[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign next = '0;
		end else begin : g_mid
			assign next = link[i+1];
		end

		fqkr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (prev_valid),
			.hit_in     (hit_in),
			.next       (next),
			.here       (link[i]),
			.hit_out    (hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.ok          <= ok;
			if (ok && (cmd.func == FUNC_DEQ)) begin
				res_q.out_key     <= link[0].key;
				res_q.out_payload <= link[0].payload;
			end else begin
				res_q.out_key     <= '0;
				res_q.out_payload <= '0;
			end
			res_q.occupancy   <= count_next;
			res_q.is_empty    <= (count_next == '0);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ rtl/fqkr_checker.sv @@
// Port-level checks of the keyed queue and their binding to the top level.
`include "fifo_queue_with_keyed_removal_macros.svh"

module fqkr_checker
	import fqkr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input res_t res
);

	// Exactly one result per accepted transaction, in the following cycle.
	`FQKR_ASSERT_NEXT(a_done_after_accept, start && !busy, done)
	`FQKR_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done)
	// The empty flag and the count must agree, and the count stays in range.
	`FQKR_ASSERT_NOW(a_empty_matches_count, done, res.is_empty == (res.occupancy == '0))
	`FQKR_ASSERT_NOW(a_count_in_range, done, res.occupancy <= CNT_BITS'(DEPTH))
	// Only a dequeue can return entry data.
	`FQKR_ASSERT_NEXT(a_data_only_on_deq, start && !busy && (cmd.func != FUNC_DEQ), (res.out_key == '0) && (res.out_payload == '0))

endmodule

bind fifo_queue_with_keyed_removal fqkr_checker u_fqkr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.res    (res)
);
